/* rtl/assert_macros.svh */
// Assertion macros used by the top level of the glyph indexer.
// Simulation builds get concurrent assertions; synthesis builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every rising clock edge outside of reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// The expression must never be true outside of reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

/* rtl/sjgi_pkg.sv */
// Package of the Shift-JIS glyph indexer: stage types, the font gap table
// and the code mapping functions. It depends on nothing else.
`timescale 1ns / 1ps

package sjgi_pkg;

  localparam int unsigned NumGaps = 18;

  localparam logic [15:0] HighLeadBase = 16'hE000;
  localparam logic [15:0] HighLeadShift = 16'h4000;
  localparam logic [7:0] FirstLead = 8'h81;
  localparam logic [7:0] SecondRowTrail = 8'h9E;
  localparam logic [15:0] SecondRowAdd = 16'h0062;
  localparam logic [15:0] FirstRowSub = 16'h0040;
  localparam logic [15:0] EucOffset = 16'h2121 + 16'h8080;
  localparam logic [15:0] EucBase = 16'h00A1;
  localparam logic [15:0] GlyphsPerRow = 16'd94;
  localparam logic [7:0] FirstPrintable = 8'h20;
  localparam logic [7:0] KanaSub = 8'h40;
  localparam logic [15:0] FullAdvance = 16'd10;
  localparam logic [15:0] HalfAdvance = 16'd5;

  localparam logic [15:0] GapStart [NumGaps] = '{
    16'hA2AF, 16'hA2C2, 16'hA2D1, 16'hA2EB, 16'hA2FA, 16'hA3A1, 16'hA3BA, 16'hA3DB,
    16'hA3FB, 16'hA4F4, 16'hA5F7, 16'hA6B9, 16'hA6D9, 16'hA7C2, 16'hA7F2, 16'hA8C1,
    16'hCFD4, 16'hF4A5
  };

  localparam logic [15:0] GapLen [NumGaps] = '{
    16'd11, 16'd8, 16'd11, 16'd7, 16'd4, 16'd15, 16'd7, 16'd6,
    16'd4, 16'd11, 16'd8, 16'd8, 16'd38, 16'd15, 16'd13, 16'd720,
    16'd43, 16'd1030
  };

  typedef struct packed {
    logic        valid;
    logic        full_width;
    logic [7:0]  lead;
    logic [7:0]  code_byte;
    logic [15:0] pen_x;
  } stage_t;

  typedef struct packed {
    logic [15:0] index;
    logic        missing;
  } glyph_t;

  typedef struct packed {
    logic        full_width;
    logic [15:0] glyph_index;
    logic        glyph_missing;
    logic [15:0] pen_x;
  } result_t;

  function automatic logic is_lead(logic [7:0] b);
    return b inside {[8'h80:8'h9F], [8'hE0:8'hFF]};
  endfunction

  function automatic logic [15:0] half_glyph(logic [7:0] b);
    logic [7:0] r;
    if (b < FirstPrintable) begin
      r = 8'h00;
    end else if (b < 8'h80) begin
      r = b - FirstPrintable;
    end else if (b < 8'hA0) begin
      r = 8'h00;
    end else begin
      r = b - KanaSub;
    end
    return {8'h00, r};
  endfunction

  function automatic glyph_t full_glyph(logic [7:0] lead, logic [7:0] trail);
    logic [15:0] code;
    logic [15:0] n;
    logic [15:0] skipped;
    logic [15:0] acc;
    logic        miss;
    glyph_t      g;
    code = {lead, trail};
    if (code >= HighLeadBase) begin
      code = code - HighLeadShift;
    end
    code = {7'(code[15:8] - FirstLead), 1'b0, code[7:0]};
    if (code[7:0] >= 8'h80) begin
      code = code - 16'd1;
    end
    if (code[7:0] >= SecondRowTrail) begin
      code = code + SecondRowAdd;
    end else begin
      code = code - FirstRowSub;
    end
    code = code + EucOffset;
    n = 16'(({8'h00, code[15:8]} - EucBase) * GlyphsPerRow) + {8'h00, code[7:0]} - EucBase;
    miss = 1'b0;
    skipped = 16'd0;
    acc = 16'd0;
    // Gap starts are sorted, so the last gap at or below the code selects
    // the running total of all gap lengths to skip.
    for (int k = 0; k < NumGaps; k++) begin
      acc = acc + GapLen[k];
      if (code >= GapStart[k]) begin
        if (code <= GapStart[k] + GapLen[k] - 16'd1) begin
          miss = 1'b1;
        end
        skipped = acc;
      end
    end
    g.missing = miss;
    g.index = miss ? 16'd0 : n - skipped;
    return g;
  endfunction

endpackage

/* rtl/sjgi_decode.sv */
// Byte decoder of the glyph indexer: holds the pending lead byte and the pen,
// and registers each glyph request for mapping. Depends on sjgi_pkg.
`timescale 1ns / 1ps

module sjgi_decode (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic [7:0]          text_byte_i,
  input  logic                new_string_i,
  input  logic [15:0]         start_x_i,
  input  logic                take_i,
  output logic                ready_o,
  output sjgi_pkg::stage_t    stage_o
);

  logic [7:0]       pending_d, pending_q;
  logic [15:0]      pen_d, pen_q;
  logic [7:0]       lead_now;
  logic [15:0]      pen_now;
  sjgi_pkg::stage_t stage_d, stage_q;

  always_comb begin
    lead_now = new_string_i ? 8'h00 : pending_q;
    pen_now = new_string_i ? start_x_i : pen_q;
    pending_d = pending_q;
    pen_d = pen_q;
    stage_d = stage_q;
    if (take_i) begin
      stage_d.valid = 1'b0;
    end
    if (fire_i) begin
      stage_d.valid = 1'b0;
      stage_d.full_width = 1'b0;
      stage_d.lead = lead_now;
      stage_d.code_byte = text_byte_i;
      stage_d.pen_x = pen_now;
      pending_d = 8'h00;
      pen_d = pen_now;
      if (text_byte_i == 8'h00) begin
        pending_d = 8'h00;
      end else if (lead_now != 8'h00) begin
        stage_d.valid = 1'b1;
        stage_d.full_width = 1'b1;
        pen_d = pen_now + sjgi_pkg::FullAdvance;
      end else if (sjgi_pkg::is_lead(text_byte_i)) begin
        pending_d = text_byte_i;
      end else begin
        stage_d.valid = 1'b1;
        pen_d = pen_now + sjgi_pkg::HalfAdvance;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 8'h00;
      pen_q <= 16'd0;
      stage_q <= '0;
    end else begin
      pending_q <= pending_d;
      pen_q <= pen_d;
      stage_q <= stage_d;
    end
  end

  assign ready_o = !stage_q.valid || take_i;
  assign stage_o = stage_q;

endmodule

/* rtl/sjgi_glyph_map.sv */
// Glyph mapper of the glyph indexer: turns a registered glyph request into a
// font index and missing flag. Depends on sjgi_pkg.
`timescale 1ns / 1ps

module sjgi_glyph_map (
  input  sjgi_pkg::stage_t  stage_i,
  output sjgi_pkg::result_t result_o
);

  sjgi_pkg::glyph_t full;

  always_comb begin
    full = sjgi_pkg::full_glyph(stage_i.lead, stage_i.code_byte);
    result_o.full_width = stage_i.full_width;
    result_o.pen_x = stage_i.pen_x;
    if (stage_i.full_width) begin
      result_o.glyph_index = full.index;
      result_o.glyph_missing = full.missing;
    end else begin
      result_o.glyph_index = sjgi_pkg::half_glyph(stage_i.code_byte);
      result_o.glyph_missing = 1'b0;
    end
  end

endmodule

/* rtl/shift_jis_glyph_index.sv */
// Top level of the Shift-JIS glyph indexer: stream ports and result register.
// Depends on sjgi_pkg, sjgi_decode, sjgi_glyph_map and assert_macros.svh.
//
//   Channel  Direction  Carries
//   s_axis   in         one text byte request with new_string and start_x
//   m_axis   out        one glyph result: index, pen x, width and missing flags
//
// One byte is taken per cycle while the request register is free or can move on;
// a glyph passes through the request register and then the result register.
// Bytes that end a string or start a two-byte code give no result.
// A stalled output holds one result while a second waits in the request register.
// Reset clears the pending lead byte and puts the pen at zero.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module shift_jis_glyph_index (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // text_byte[7:0], new_string[8], start_x[24:9], zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // glyph_index[15:0], pen_x[31:16]
  output logic [1:0]  m_axis_tuser   // full_width[0], glyph_missing[1]
);

  sjgi_pkg::stage_t  stage;
  sjgi_pkg::result_t result;
  sjgi_pkg::result_t out_d, out_q;
  logic              out_valid_d, out_valid_q;
  logic              out_free;
  logic              in_fire;

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  sjgi_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (in_fire),
    .text_byte_i  (s_axis_tdata[7:0]),
    .new_string_i (s_axis_tdata[8]),
    .start_x_i    (s_axis_tdata[24:9]),
    .take_i       (out_free),
    .ready_o      (s_axis_tready),
    .stage_o      (stage)
  );

  sjgi_glyph_map u_glyph_map (
    .stage_i  (stage),
    .result_o (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_d = out_q;
    if (out_free) begin
      out_valid_d = stage.valid;
      if (stage.valid) begin
        out_d = result;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = {out_q.pen_x, out_q.glyph_index};
  assign m_axis_tuser = {out_q.glyph_missing, out_q.full_width};

  `ASSERT_PROP(missing_has_zero_index, clk_i, rst_ni,
    (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata[15:0] == 16'd0))
  `ASSERT_NEVER(missing_half_width, clk_i, rst_ni,
    m_axis_tvalid && m_axis_tuser[1] && !m_axis_tuser[0])
  `ASSERT_PROP(stall_only_when_full, clk_i, rst_ni,
    !s_axis_tready |-> (stage.valid && out_valid_q && !m_axis_tready))
  `ASSERT_PROP(request_moves_to_output, clk_i, rst_ni,
    (stage.valid && out_free) |=> m_axis_tvalid)

endmodule

/* tb/sv/shift_jis_glyph_index_test.sv */
// Self-checking testbench for shift_jis_glyph_index: directed and random text byte
// requests with idle gaps and back-pressure, compared against an in-bench predictor.
// Depends only on the RTL of shift_jis_glyph_index.
`timescale 1ns / 1ps

module shift_jis_glyph_index_test;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandomBytes = 1250;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned HoldOffCycles = 250;
  localparam int unsigned NumFontGaps = 18;
  localparam logic [7:0] EndOfString = 8'h00;
  localparam logic [15:0] FullStep = 16'd10;
  localparam logic [15:0] HalfStep = 16'd5;

  // EUC codes where the font has no glyphs, and how many codes each hole spans.
  localparam int unsigned FontGapFirst [NumFontGaps] = '{
    'hA2AF, 'hA2C2, 'hA2D1, 'hA2EB, 'hA2FA, 'hA3A1, 'hA3BA, 'hA3DB, 'hA3FB,
    'hA4F4, 'hA5F7, 'hA6B9, 'hA6D9, 'hA7C2, 'hA7F2, 'hA8C1, 'hCFD4, 'hF4A5
  };
  localparam int unsigned FontGapSize [NumFontGaps] = '{
    11, 8, 11, 7, 4, 15, 7, 6, 4, 11, 8, 8, 38, 15, 13, 720, 43, 1030
  };

  typedef struct {
    bit        full_width;
    bit [15:0] glyph_index;
    bit        glyph_missing;
    bit [15:0] pen_x;
  } glyph_rec_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  glyph_rec_t  pending_glyphs [$];
  bit [7:0]    lead_held;
  bit [15:0]   pen_now;
  int unsigned mismatch_count;
  int unsigned bytes_sent;
  int unsigned cycle_count;
  int unsigned hold_off_left;
  int unsigned stall_left;
  bit          tx_idle_on;
  bit          rx_idle_on;

  shift_jis_glyph_index uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Two-byte code to font index: Shift-JIS to EUC, 94 glyphs per row, then
  // skip past every font hole below the code.
  function automatic void map_kanji(input bit [7:0] lead, input bit [7:0] trail,
                                    output bit [15:0] index, output bit missing);
    bit [15:0] code;
    bit [15:0] n;
    bit [7:0]  row;
    code = {lead, trail};
    if (code >= 16'hE000) begin
      code = code - 16'h4000;
    end
    row = code[15:8] - 8'h81;
    code = {row[6:0], 1'b0, code[7:0]};
    if (code[7:0] >= 8'h80) begin
      code = code - 16'd1;
    end
    if (code[7:0] >= 8'h9E) begin
      code = code + 16'h0062;
    end else begin
      code = code - 16'h0040;
    end
    code = code + 16'hA1A1;
    n = ({8'h00, code[15:8]} - 16'h00A1) * 16'd94 + {8'h00, code[7:0]} - 16'h00A1;
    missing = 1'b0;
    for (int k = 0; k < NumFontGaps; k++) begin
      if (!missing && code >= FontGapFirst[k]) begin
        if (code <= FontGapFirst[k] + FontGapSize[k] - 1) begin
          missing = 1'b1;
          n = 16'd0;
        end else begin
          n = n - 16'(FontGapSize[k]);
        end
      end
    end
    index = n;
  endfunction

  function automatic bit [15:0] half_width_index(input bit [7:0] b);
    if (b < 8'h20) begin
      return 16'd0;
    end else if (b < 8'h80) begin
      return {8'h00, b - 8'h20};
    end else if (b < 8'hA0) begin
      return 16'd0;
    end
    return {8'h00, b - 8'h40};
  endfunction

  function automatic void predict_glyph(input bit [7:0] text_byte, input bit new_string,
                                        input bit [15:0] start_x, output bit made,
                                        output glyph_rec_t g);
    bit [15:0] idx;
    bit        miss;
    made = 1'b0;
    g = '{default: 0};
    if (new_string) begin
      pen_now = start_x;
      lead_held = 8'h00;
    end
    if (text_byte == EndOfString) begin
      lead_held = 8'h00;
      return;
    end
    if (lead_held != 8'h00) begin
      map_kanji(lead_held, text_byte, idx, miss);
      lead_held = 8'h00;
      g.full_width = 1'b1;
      g.glyph_index = idx;
      g.glyph_missing = miss;
      g.pen_x = pen_now;
      pen_now = pen_now + FullStep;
      made = 1'b1;
    end else if ((text_byte >= 8'h80 && text_byte < 8'hA0) || text_byte >= 8'hE0) begin
      lead_held = text_byte;
    end else begin
      g.glyph_index = half_width_index(text_byte);
      g.pen_x = pen_now;
      pen_now = pen_now + HalfStep;
      made = 1'b1;
    end
  endfunction

  function automatic int unsigned pick_idle_len();
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(12, 40);
    end
    return $urandom_range(1, 3);
  endfunction

  function automatic bit [7:0] rand_half_byte();
    case ($urandom_range(0, 9))
      0: return 8'($urandom_range(8'h01, 8'h1F));
      1, 2, 3: return 8'($urandom_range(8'hA0, 8'hDF));
      default: return 8'($urandom_range(8'h20, 8'h7F));
    endcase
  endfunction

  function automatic bit [7:0] rand_lead();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? 8'h80 : 8'($urandom_range(8'hF0, 8'hFF));
      1, 2, 3: return 8'($urandom_range(8'hE0, 8'hEF));
      default: return 8'($urandom_range(8'h81, 8'h9F));
    endcase
  endfunction

  function automatic bit [7:0] rand_trail();
    case ($urandom_range(0, 9))
      0: return 8'($urandom_range(1, 255));
      1, 2, 3, 4: return 8'($urandom_range(8'h80, 8'hFC));
      default: return 8'($urandom_range(8'h40, 8'h7E));
    endcase
  endfunction

  task automatic send_text_byte(input bit [7:0] text_byte, input bit new_string,
                                input bit [15:0] start_x);
    int unsigned gap;
    bit          made;
    glyph_rec_t  g;
    gap = (tx_idle_on && $urandom_range(0, 2) == 0) ? pick_idle_len() : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, start_x, new_string, text_byte};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_glyph(text_byte, new_string, start_x, made, g);
    if (made) begin
      pending_glyphs.push_back(g);
    end
    bytes_sent++;
  endtask

  task automatic check_glyph();
    glyph_rec_t want;
    if (pending_glyphs.size() == 0) begin
      $display("%0t: unexpected glyph, expected none, actual data %h user %h",
               $time, m_axis_tdata, m_axis_tuser);
      mismatch_count++;
      return;
    end
    want = pending_glyphs.pop_front();
    if (m_axis_tuser[0] !== want.full_width) begin
      $display("%0t: full_width expected %0d actual %0d", $time, want.full_width,
               m_axis_tuser[0]);
      mismatch_count++;
    end
    if (m_axis_tdata[15:0] !== want.glyph_index) begin
      $display("%0t: glyph_index expected %h actual %h", $time, want.glyph_index,
               m_axis_tdata[15:0]);
      mismatch_count++;
    end
    if (m_axis_tuser[1] !== want.glyph_missing) begin
      $display("%0t: glyph_missing expected %0d actual %0d", $time, want.glyph_missing,
               m_axis_tuser[1]);
      mismatch_count++;
    end
    if (m_axis_tdata[31:16] !== want.pen_x) begin
      $display("%0t: pen_x expected %h actual %h", $time, want.pen_x, m_axis_tdata[31:16]);
      mismatch_count++;
    end
  endtask

  // The result side: checks each accepted glyph and decides when to stall.
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        check_glyph();
      end
      if (hold_off_left != 0) begin
        hold_off_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
        stall_left = pick_idle_len() - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // The pen starts at zero after reset, with no new string marked.
  task automatic test_reset_state();
    send_text_byte(8'h41, 1'b0, 16'h1234);
  endtask

  task automatic test_half_width_and_wrap();
    send_text_byte(8'h01, 1'b1, 16'hFFFF);
    send_text_byte(8'h20, 1'b0, 16'h0000);
    send_text_byte(8'h7F, 1'b0, 16'h0000);
    send_text_byte(8'hA0, 1'b0, 16'h0000);
    send_text_byte(8'hDF, 1'b0, 16'h0000);
  endtask

  task automatic test_full_width_codes();
    send_text_byte(8'h80, 1'b1, 16'hFFFA);
    send_text_byte(8'h01, 1'b0, 16'h0000);
    send_text_byte(8'h9F, 1'b0, 16'h0000);
    send_text_byte(8'hFC, 1'b0, 16'h0000);
    send_text_byte(8'hE0, 1'b0, 16'h0000);
    send_text_byte(8'h40, 1'b0, 16'h0000);
    send_text_byte(8'hFF, 1'b0, 16'h0000);
    send_text_byte(8'hFF, 1'b0, 16'h0000);
  endtask

  // A second lead byte while one is held is taken as the trail byte.
  task automatic test_lead_after_lead();
    send_text_byte(8'h81, 1'b1, 16'h0100);
    send_text_byte(8'h81, 1'b0, 16'h0000);
    send_text_byte(8'h41, 1'b0, 16'h0000);
  endtask

  // Both the end of a string and a new string drop a held lead byte.
  task automatic test_end_of_string();
    send_text_byte(8'h88, 1'b1, 16'h0200);
    send_text_byte(EndOfString, 1'b0, 16'h0000);
    send_text_byte(8'h41, 1'b0, 16'h0000);
    send_text_byte(8'h88, 1'b0, 16'h0000);
    send_text_byte(8'h41, 1'b1, 16'h0300);
  endtask

  // Codes at the start of the first and of the last font hole.
  task automatic test_missing_glyph();
    send_text_byte(8'h81, 1'b1, 16'h0400);
    send_text_byte(8'hAD, 1'b0, 16'h0000);
    send_text_byte(8'hEA, 1'b0, 16'h0000);
    send_text_byte(8'hA3, 1'b0, 16'h0000);
  endtask

  // The result side holds off long enough for the block to stop taking requests.
  task automatic test_backpressure();
    tx_idle_on = 1'b0;
    hold_off_left = HoldOffCycles;
    repeat (40) begin
      send_text_byte(rand_half_byte(), 1'b0, 16'($urandom_range(0, 65535)));
    end
    tx_idle_on = 1'b1;
  endtask

  // Mostly well-formed strings of mixed glyphs, with some bursts of raw bytes.
  task automatic test_random_text();
    int unsigned first_count;
    int unsigned glyphs;
    bit          mark;
    first_count = bytes_sent;
    while (bytes_sent - first_count < RandomBytes) begin
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 10)) begin
          send_text_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0,
                         16'($urandom_range(0, 65535)));
        end
      end else begin
        mark = ($urandom_range(0, 4) != 0);
        glyphs = $urandom_range(1, 12);
        repeat (glyphs) begin
          if ($urandom_range(0, 1) == 0) begin
            send_text_byte(rand_lead(), mark, 16'($urandom_range(0, 65535)));
            send_text_byte(rand_trail(), 1'b0, 16'($urandom_range(0, 65535)));
          end else begin
            send_text_byte(rand_half_byte(), mark, 16'($urandom_range(0, 65535)));
          end
          mark = 1'b0;
        end
        if ($urandom_range(0, 4) != 0) begin
          send_text_byte(EndOfString, 1'b0, 16'($urandom_range(0, 65535)));
        end
      end
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    lead_held = 8'h00;
    pen_now = 16'h0000;
    mismatch_count = 0;
    bytes_sent = 0;
    cycle_count = 0;
    hold_off_left = 0;
    stall_left = 0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_half_width_and_wrap();
    test_full_width_codes();
    test_lead_after_lead();
    test_end_of_string();
    test_missing_glyph();
    test_backpressure();
    test_random_text();
    s_axis_tvalid <= 1'b0;
    while (pending_glyphs.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/sjgi_pkg.sv
rtl/sjgi_decode.sv
rtl/sjgi_glyph_map.sv
rtl/shift_jis_glyph_index.sv
tb/sv/shift_jis_glyph_index_test.sv
